FILE: rtl/core/gac_pkg.sv
`timescale 1ns / 1ps

package gac_pkg;

	localparam int CODE_W = 16;
	localparam int DIM_W  = 10;
	localparam int FH_W   = 9;
	localparam int STAT_W = 2;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 72;

	localparam logic [CODE_W-1:0] NEWLINE_CODE = 16'd10;
	localparam logic [FH_W-1:0]   FH_RESET     = 9'd32;

	localparam logic [STAT_W-1:0] STAT_HIT     = 2'd0;
	localparam logic [STAT_W-1:0] STAT_PLACE   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EVICT   = 2'd2;
	localparam logic [STAT_W-1:0] STAT_NEWLINE = 2'd3;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_DECIDE,
		ST_SLOTRD,
		ST_LINK1,
		ST_LINK2,
		ST_RESP
	} gac_state_t;

	typedef struct packed {
		logic take;
		logic accept;
		logic clr;
		logic lookup;
		logic place;
		logic select;
		logic capture;
		logic link1;
		logic link2;
		logic respond;
	} gac_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic newline;
		logic map_hit;
		logic free;
		logic out_free;
	} gac_status_t;

endpackage

FILE: rtl/core/glyph_atlas_lru_cache.sv
`timescale 1ns / 1ps

// LRU glyph cache for a square atlas of font_height cells. After reset the
// character map is swept clear, one entry per cycle, across all CHAR_CODES
// entries; s_axis_tready stays low during that sweep. Items are handled one
// at a time: a newline goes straight to the response, a free-cell placement
// follows a map read, and a hit or an eviction takes a map read, a slot read,
// then link1 and link2 recency-list updates via the single-write-port slot
// memories, plus any wait for the output register. One result per input.
module glyph_atlas_lru_cache #(
	parameter int ATLAS_SIZE = 1024,
	parameter int MAX_SLOTS  = 1024,
	parameter int CHAR_CODES = 65536
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// char_code[15:0], glyph_width[25:16], glyph_height[35:26], zero pad
	input  logic [gac_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// status[1:0], cell_x[11:2], cell_y[21:12], upload_width[31:22],
	// upload_height[41:32], stored_width[51:42], evicted_char[67:52], zero pad
	output logic [gac_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [gac_pkg::FH_W-1:0]            cfg_data
);

	import gac_pkg::*;

	gac_cmd_t    cmd;
	gac_status_t st;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = cmd.take;

	gac_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.st(st),
		.cmd(cmd)
	);

	gac_datapath #(
		.ATLAS_SIZE(ATLAS_SIZE),
		.MAX_SLOTS(MAX_SLOTS),
		.CHAR_CODES(CHAR_CODES)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.st(st),
		.in_code(s_axis_tdata[15:0]),
		.in_gw(s_axis_tdata[25:16]),
		.in_gh(s_axis_tdata[35:26]),
		.cfg_we(cfg_valid),
		.cfg_wdata(cfg_data),
		.out_ready(m_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_data(m_axis_tdata)
	);

endmodule

FILE: rtl/core/gac_ram.sv
`timescale 1ns / 1ps

module gac_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/core/gac_datapath.sv
`timescale 1ns / 1ps

module gac_datapath #(
	parameter int ATLAS_SIZE = 1024,
	parameter int MAX_SLOTS  = 1024,
	parameter int CHAR_CODES = 65536
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  gac_pkg::gac_cmd_t                   cmd,
	output gac_pkg::gac_status_t                st,
	input  logic [gac_pkg::CODE_W-1:0]          in_code,
	input  logic [gac_pkg::DIM_W-1:0]           in_gw,
	input  logic [gac_pkg::DIM_W-1:0]           in_gh,
	input  logic                                cfg_we,
	input  logic [gac_pkg::FH_W-1:0]            cfg_wdata,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic [gac_pkg::OUT_TDATA_W-1:0]     out_data
);

	import gac_pkg::*;

	localparam int SW = $clog2(MAX_SLOTS);
	localparam int KW = $clog2(CHAR_CODES);
	localparam int AW = $clog2(ATLAS_SIZE);
	localparam int CW = $clog2(ATLAS_SIZE + 512);
	localparam int UW = $clog2(MAX_SLOTS + 1);
	localparam int MW = SW + 1;

	// code modulo CHAR_CODES by conditional subtraction; quotient fits 8 bits
	function automatic logic [KW-1:0] code_key(input logic [CODE_W-1:0] c);
		logic [CODE_W-1:0] r;
		r = c;
		for (int k = 7; k >= 0; k--) begin
			if (32'(r) >= (CHAR_CODES << k)) begin
				r = r - CODE_W'(CHAR_CODES << k);
			end
		end
		return r[KW-1:0];
	endfunction

	function automatic logic [DIM_W-1:0] to_dim(input logic [AW-1:0] v);
		logic [AW+DIM_W-1:0] t;
		t = {{DIM_W{1'b0}}, v};
		return t[DIM_W-1:0];
	endfunction

	logic [CODE_W-1:0] code_q;
	logic [DIM_W-1:0]  gw_q, gh_q;
	logic [KW-1:0]     key_q, evkey_q, clr_q;
	logic [FH_W-1:0]   fh_q;
	logic [UW-1:0]     used_q;
	logic [SW-1:0]     newest_q, oldest_q, s_q, o_q, n_q;
	logic              evict_q;
	logic [CW-1:0]     cur_x_q, cur_y_q;

	logic [STAT_W-1:0] res_stat_q, out_stat_q;
	logic [DIM_W-1:0]  res_cx_q, res_cy_q, res_uw_q, res_uh_q, res_sw_q;
	logic [DIM_W-1:0]  out_cx_q, out_cy_q, out_uw_q, out_uh_q, out_sw_q;
	logic [CODE_W-1:0] res_ev_q, out_ev_q;
	logic              out_valid_q;

	logic [MW-1:0]     map_rdata, map_wdata;
	logic [KW-1:0]     map_waddr;
	logic              map_we;
	logic [SW-1:0]     sel_slot, used_slot;
	logic [CODE_W-1:0] char_rd;
	logic [2*AW-1:0]   cell_rd;
	logic [DIM_W-1:0]  width_rd;
	logic [SW-1:0]     newer_rd, older_rd;
	logic              at_newest, at_oldest, has_used;
	logic              chw_we, older_we, newer_we;
	logic [SW-1:0]     chw_addr, older_addr, older_wdata, newer_addr, newer_wdata;
	logic [CW-1:0]     fh_ext, next_x;

	assign used_slot = used_q[SW-1:0];
	assign has_used  = (used_q != '0);
	assign at_newest = (s_q == newest_q);
	assign at_oldest = (s_q == oldest_q);
	assign sel_slot  = map_rdata[MW-1] ? map_rdata[SW-1:0] : oldest_q;
	assign fh_ext    = CW'(fh_q);
	assign next_x    = cur_x_q + fh_ext;

	assign st.clear_done = (clr_q == KW'(CHAR_CODES - 1));
	assign st.newline    = (in_code == NEWLINE_CODE);
	assign st.map_hit    = map_rdata[MW-1];
	assign st.free       = (cur_x_q < CW'(ATLAS_SIZE)) && (cur_y_q < CW'(ATLAS_SIZE)) &&
		(used_q < UW'(MAX_SLOTS));
	assign st.out_free   = !out_valid_q || out_ready;

	// char -> slot map
	always_comb begin
		map_we    = cmd.clr || cmd.place || ((cmd.link1 || cmd.link2) && evict_q);
		map_waddr = key_q;
		map_wdata = '0;
		if (cmd.clr) begin
			map_waddr = clr_q;
		end else if (cmd.place) begin
			map_wdata = {1'b1, used_slot};
		end else if (cmd.link1) begin
			map_waddr = evkey_q;
		end else begin
			map_wdata = {1'b1, s_q};
		end
	end

	gac_ram #(.WIDTH(MW), .DEPTH(CHAR_CODES)) u_map (
		.clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
		.re(cmd.lookup), .raddr(key_q), .rdata(map_rdata)
	);

	assign chw_we   = cmd.place || (cmd.link1 && evict_q);
	assign chw_addr = cmd.place ? used_slot : s_q;

	gac_ram #(.WIDTH(CODE_W), .DEPTH(MAX_SLOTS)) u_char (
		.clk(clk), .we(chw_we), .waddr(chw_addr), .wdata(code_q),
		.re(cmd.select), .raddr(sel_slot), .rdata(char_rd)
	);

	gac_ram #(.WIDTH(DIM_W), .DEPTH(MAX_SLOTS)) u_width (
		.clk(clk), .we(chw_we), .waddr(chw_addr), .wdata(gw_q),
		.re(cmd.select), .raddr(sel_slot), .rdata(width_rd)
	);

	gac_ram #(.WIDTH(2 * AW), .DEPTH(MAX_SLOTS)) u_cell (
		.clk(clk), .we(cmd.place), .waddr(used_slot),
		.wdata({cur_y_q[AW-1:0], cur_x_q[AW-1:0]}),
		.re(cmd.select), .raddr(sel_slot), .rdata(cell_rd)
	);

	// recency list links; append at newest end on place, unlink in link1, relink at newest end in link2
	always_comb begin
		older_we    = 1'b0;
		older_addr  = s_q;
		older_wdata = newest_q;
		newer_we    = 1'b0;
		newer_addr  = newest_q;
		newer_wdata = s_q;
		if (cmd.place) begin
			older_we    = has_used;
			older_addr  = used_slot;
			newer_we    = has_used;
			newer_wdata = used_slot;
		end else if (cmd.link1) begin
			older_we    = !at_newest;
			older_addr  = n_q;
			older_wdata = o_q;
			newer_we    = !at_newest && !at_oldest;
			newer_addr  = o_q;
			newer_wdata = n_q;
		end else if (cmd.link2) begin
			older_we = !at_newest;
			newer_we = !at_newest;
		end
	end

	gac_ram #(.WIDTH(SW), .DEPTH(MAX_SLOTS)) u_older (
		.clk(clk), .we(older_we), .waddr(older_addr), .wdata(older_wdata),
		.re(cmd.select), .raddr(sel_slot), .rdata(older_rd)
	);

	gac_ram #(.WIDTH(SW), .DEPTH(MAX_SLOTS)) u_newer (
		.clk(clk), .we(newer_we), .waddr(newer_addr), .wdata(newer_wdata),
		.re(cmd.select), .raddr(sel_slot), .rdata(newer_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fh_q        <= FH_RESET;
			clr_q       <= '0;
			used_q      <= '0;
			newest_q    <= '0;
			oldest_q    <= '0;
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				fh_q <= cfg_wdata;
			end
			if (cmd.clr) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.place) begin
				used_q   <= used_q + 1'b1;
				newest_q <= used_slot;
				if (!has_used) begin
					oldest_q <= used_slot;
				end
				if (next_x >= CW'(ATLAS_SIZE)) begin
					cur_x_q <= '0;
					cur_y_q <= cur_y_q + fh_ext;
				end else begin
					cur_x_q <= next_x;
				end
			end
			if (cmd.link1 && !at_newest && at_oldest) begin
				oldest_q <= n_q;
			end
			if (cmd.link2 && !at_newest) begin
				newest_q <= s_q;
			end
			if (cmd.respond) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			code_q <= in_code;
			gw_q   <= in_gw;
			gh_q   <= in_gh;
			key_q  <= code_key(in_code);
			if (in_code == NEWLINE_CODE) begin
				res_stat_q <= STAT_NEWLINE;
				res_cx_q   <= '0;
				res_cy_q   <= '0;
				res_uw_q   <= '0;
				res_uh_q   <= '0;
				res_sw_q   <= '0;
				res_ev_q   <= '0;
			end
		end
		if (cmd.place) begin
			res_stat_q <= STAT_PLACE;
			res_cx_q   <= to_dim(cur_x_q[AW-1:0]);
			res_cy_q   <= to_dim(cur_y_q[AW-1:0]);
			res_uw_q   <= gw_q;
			res_uh_q   <= gh_q;
			res_sw_q   <= gw_q;
			res_ev_q   <= '0;
		end
		if (cmd.select) begin
			s_q     <= sel_slot;
			evict_q <= !map_rdata[MW-1];
		end
		if (cmd.capture) begin
			o_q        <= older_rd;
			n_q        <= newer_rd;
			evkey_q    <= code_key(char_rd);
			res_stat_q <= evict_q ? STAT_EVICT : STAT_HIT;
			res_cx_q   <= to_dim(cell_rd[AW-1:0]);
			res_cy_q   <= to_dim(cell_rd[2*AW-1:AW]);
			res_uw_q   <= evict_q ? DIM_W'(fh_q) : '0;
			res_uh_q   <= evict_q ? DIM_W'(fh_q) : '0;
			res_sw_q   <= evict_q ? gw_q : width_rd;
			res_ev_q   <= evict_q ? char_rd : '0;
		end
		if (cmd.respond) begin
			out_stat_q <= res_stat_q;
			out_cx_q   <= res_cx_q;
			out_cy_q   <= res_cy_q;
			out_uw_q   <= res_uw_q;
			out_uh_q   <= res_uh_q;
			out_sw_q   <= res_sw_q;
			out_ev_q   <= res_ev_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = {4'd0, out_ev_q, out_sw_q, out_uh_q, out_uw_q, out_cy_q, out_cx_q,
		out_stat_q};

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= UW'(MAX_SLOTS))
		else $error("slot count beyond capacity");

	a_place_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.place |-> st.free)
		else $error("placement with no free cell");

	a_resp_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.respond |-> st.out_free)
		else $error("result overwrites a pending transaction");

endmodule

FILE: rtl/core/gac_ctrl.sv
`timescale 1ns / 1ps

module gac_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  gac_pkg::gac_status_t st,
	output gac_pkg::gac_cmd_t    cmd
);

	import gac_pkg::*;

	gac_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (st.clear_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				cmd.take   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid) begin
					state_d = st.newline ? ST_RESP : ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				cmd.lookup = 1'b1;
				state_d    = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (!st.map_hit && st.free) begin
					cmd.place = 1'b1;
					state_d   = ST_RESP;
				end else begin
					cmd.select = 1'b1;
					state_d    = ST_SLOTRD;
				end
			end
			ST_SLOTRD: begin
				cmd.capture = 1'b1;
				state_d     = ST_LINK1;
			end
			ST_LINK1: begin
				cmd.link1 = 1'b1;
				state_d   = ST_LINK2;
			end
			ST_LINK2: begin
				cmd.link2 = 1'b1;
				state_d   = ST_RESP;
			end
			ST_RESP: begin
				if (st.out_free) begin
					cmd.respond = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_lookup_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && in_valid && !st.newline) |=> state_q == ST_LOOKUP)
		else $error("accepted item skipped the map lookup");

endmodule
